@@ rtl/core/aifd_pkg.sv @@
// Shared constants, register indexes and the arctangent table for the fall detector.
`timescale 1ns / 1ps
`default_nettype none
package aifd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int ANGLE_W     = 25;

  localparam logic [CFG_INDEX_W-1:0] REG_IMPACT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM = 2'd2;

  localparam logic [15:0] IMPACT_RST  = 16'd10240;
  localparam logic [14:0] TILT_RST    = 15'd15360;
  localparam logic [31:0] CONFIRM_RST = 32'd2000;

  localparam logic [14:0] TILT_MAX = 15'd23040;

  localparam logic [1:0] ST_NORMAL    = 2'd0;
  localparam logic [1:0] ST_IMPACT    = 2'd1;
  localparam logic [1:0] ST_CANDIDATE = 2'd2;
  localparam logic [1:0] ST_CONFIRMED = 2'd3;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ANGLE_W-1:0] atan_tbl(input logic [4:0] idx);
    logic [ANGLE_W-1:0] v;
    unique case (idx)
      5'd0:    v = 25'd2949120;
      5'd1:    v = 25'd1740967;
      5'd2:    v = 25'd919879;
      5'd3:    v = 25'd466945;
      5'd4:    v = 25'd234379;
      5'd5:    v = 25'd117304;
      5'd6:    v = 25'd58666;
      5'd7:    v = 25'd29335;
      5'd8:    v = 25'd14668;
      5'd9:    v = 25'd7334;
      5'd10:   v = 25'd3667;
      5'd11:   v = 25'd1833;
      5'd12:   v = 25'd917;
      5'd13:   v = 25'd458;
      5'd14:   v = 25'd229;
      5'd15:   v = 25'd115;
      5'd16:   v = 25'd57;
      5'd17:   v = 25'd29;
      5'd18:   v = 25'd14;
      5'd19:   v = 25'd7;
      5'd20:   v = 25'd4;
      5'd21:   v = 25'd2;
      5'd22:   v = 25'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/accel_impact_fall_detector.sv @@
// Top level: accelerometer magnitude, tilt and fall detection.
// One request at a time: in_stall stays high until the result register takes the result.
// Squares take one multiplier bit a cycle, roots one result bit, the CORDIC one iteration.
// The result register holds a finished result while the next request is taken.
// Reset (synchronous, active low) restores register defaults and clears candidate and status.
`timescale 1ns / 1ps
`default_nettype none
module accel_impact_fall_detector #(
  parameter int SAMPLE_WIDTH = aifd_pkg::SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH   = aifd_pkg::TIME_WIDTH_DEF,
  parameter int CORDIC_STEPS = aifd_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [aifd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [aifd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  signed [SAMPLE_WIDTH-1:0]      in_accel_x,
  input  wire  signed [SAMPLE_WIDTH-1:0]      in_accel_y,
  input  wire  signed [SAMPLE_WIDTH-1:0]      in_accel_z,
  input  wire  [TIME_WIDTH-1:0]               in_time_ms,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [15:0]                         out_magnitude,
  output logic [14:0]                         out_tilt_angle,
  output logic                                out_impact,
  output logic                                out_fall_confirmed,
  output logic [1:0]                          out_status
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PW    = 2 * SW;
  localparam int SUMW  = 2 * SW + 2;
  localparam int RW    = SW + 1;
  localparam int REMW  = SW + 4;
  localparam int CW    = SW + 13;
  localparam int ZW    = aifd_pkg::ANGLE_W;
  localparam int CNTW  = $clog2(SW + CORDIC_STEPS + 2);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQR  = 5'b00010,
    S_ROOT = 5'b00100,
    S_ROT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  logic [15:0] thr_impact_r;
  logic [14:0] thr_tilt_r;
  logic [31:0] confirm_r;

  logic [SW-1:0] mp_x_r, mp_y_r, mp_z_r, az_abs_r;
  logic [PW-1:0] mc_x_r, mc_y_r, mc_z_r;
  logic [PW-1:0] acc_x_r, acc_y_r, acc_z_r;
  logic [PW-1:0] acc_x_nxt, acc_y_nxt, acc_z_nxt;
  logic [TIME_WIDTH-1:0] now_r;

  logic [SUMW-1:0] rad_m_r, rad_h_r;
  logic [REMW-1:0] rem_m_r, rem_h_r, rs_m, rs_h, tr_m, tr_h;
  logic [RW-1:0]   root_m_r, root_h_r, root_m_nxt, root_h_nxt;
  logic [REMW-1:0] rem_m_nxt, rem_h_nxt;

  logic signed [CW-1:0] x_r, y_r, sx, sy;
  logic signed [ZW-1:0] z_r, zt;

  logic                  cand_r;
  logic [TIME_WIDTH-1:0] cand_start_r;
  logic [1:0]            status_r;

  logic [31:0] mag32, dur32;
  logic [ZW-1:0] zr;
  logic [14:0] tilt;
  logic impact, cand_hit, confirmed;
  logic [TIME_WIDTH-1:0] start_eff, dur;
  logic [1:0] status_nxt;
  logic take;

  function automatic logic [SW-1:0] abs_s(input logic [SW-1:0] a);
    return a[SW-1] ? (~a + 1'b1) : a;
  endfunction

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_impact_r <= aifd_pkg::IMPACT_RST;
      thr_tilt_r   <= aifd_pkg::TILT_RST;
      confirm_r    <= aifd_pkg::CONFIRM_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        aifd_pkg::REG_IMPACT:  thr_impact_r <= cfg_data[15:0];
        aifd_pkg::REG_TILT:    thr_tilt_r   <= cfg_data[14:0];
        aifd_pkg::REG_CONFIRM: confirm_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // shift-add squaring, one multiplier bit a cycle
  assign acc_x_nxt = acc_x_r + (mp_x_r[0] ? mc_x_r : '0);
  assign acc_y_nxt = acc_y_r + (mp_y_r[0] ? mc_y_r : '0);
  assign acc_z_nxt = acc_z_r + (mp_z_r[0] ? mc_z_r : '0);

  // digit-by-digit square roots, one result bit a cycle
  assign rs_m = {rem_m_r[REMW-3:0], rad_m_r[SUMW-1 -: 2]};
  assign rs_h = {rem_h_r[REMW-3:0], rad_h_r[SUMW-1 -: 2]};
  assign tr_m = REMW'({root_m_r, 2'b01});
  assign tr_h = REMW'({root_h_r, 2'b01});
  always_comb begin
    if (rs_m >= tr_m) begin
      rem_m_nxt  = rs_m - tr_m;
      root_m_nxt = {root_m_r[RW-2:0], 1'b1};
    end else begin
      rem_m_nxt  = rs_m;
      root_m_nxt = {root_m_r[RW-2:0], 1'b0};
    end
    if (rs_h >= tr_h) begin
      rem_h_nxt  = rs_h - tr_h;
      root_h_nxt = {root_h_r[RW-2:0], 1'b1};
    end else begin
      rem_h_nxt  = rs_h;
      root_h_nxt = {root_h_r[RW-2:0], 1'b0};
    end
  end

  assign sx = x_r >>> cnt_r;
  assign sy = y_r >>> cnt_r;
  assign zt = $signed(aifd_pkg::atan_tbl(5'(cnt_r)));

  // finish: tilt rounding and clamping, impact and confirmation tests, status update
  always_comb begin
    zr = ZW'(z_r + ZW'(128)) >> 8;
    if (z_r[ZW-1]) begin
      tilt = '0;
    end else if (zr > ZW'(aifd_pkg::TILT_MAX)) begin
      tilt = aifd_pkg::TILT_MAX;
    end else begin
      tilt = zr[14:0];
    end
    mag32     = 32'(root_m_r);
    impact    = mag32 > {16'd0, thr_impact_r};
    cand_hit  = tilt > thr_tilt_r;
    start_eff = cand_r ? cand_start_r : now_r;
    dur       = now_r - start_eff;
    dur32     = 32'(dur);
    confirmed = cand_hit && (dur32 >= confirm_r);
    status_nxt = impact ? aifd_pkg::ST_IMPACT : status_r;
    priority if (cand_hit) begin
      if (confirmed) begin
        status_nxt = aifd_pkg::ST_CONFIRMED;
      end else if (!impact) begin
        status_nxt = aifd_pkg::ST_CANDIDATE;
      end
    end else if (!impact) begin
      status_nxt = aifd_pkg::ST_NORMAL;
    end
  end

  assign take = (state_r == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SQR;
          cnt_nxt   = '0;
        end
      end
      S_SQR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(SW - 1)) begin
          state_nxt = S_ROOT;
          cnt_nxt   = '0;
        end
      end
      S_ROOT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(RW - 1)) begin
          state_nxt = S_ROT;
          cnt_nxt   = '0;
        end
      end
      S_ROT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(CORDIC_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      cand_r       <= 1'b0;
      cand_start_r <= '0;
      status_r     <= aifd_pkg::ST_NORMAL;
      out_valid    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        cand_r       <= cand_hit;
        cand_start_r <= cand_hit ? start_eff : '0;
        status_r     <= status_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        mp_x_r   <= abs_s(in_accel_x);
        mp_y_r   <= abs_s(in_accel_y);
        mp_z_r   <= abs_s(in_accel_z);
        az_abs_r <= abs_s(in_accel_z);
        mc_x_r   <= PW'(abs_s(in_accel_x));
        mc_y_r   <= PW'(abs_s(in_accel_y));
        mc_z_r   <= PW'(abs_s(in_accel_z));
        acc_x_r  <= '0;
        acc_y_r  <= '0;
        acc_z_r  <= '0;
        now_r    <= in_time_ms;
      end
      S_SQR: begin
        acc_x_r <= acc_x_nxt;
        acc_y_r <= acc_y_nxt;
        acc_z_r <= acc_z_nxt;
        mp_x_r  <= mp_x_r >> 1;
        mp_y_r  <= mp_y_r >> 1;
        mp_z_r  <= mp_z_r >> 1;
        mc_x_r  <= mc_x_r << 1;
        mc_y_r  <= mc_y_r << 1;
        mc_z_r  <= mc_z_r << 1;
        rad_m_r  <= SUMW'(acc_x_nxt) + SUMW'(acc_y_nxt) + SUMW'(acc_z_nxt);
        rad_h_r  <= SUMW'(acc_x_nxt) + SUMW'(acc_y_nxt);
        rem_m_r  <= '0;
        rem_h_r  <= '0;
        root_m_r <= '0;
        root_h_r <= '0;
      end
      S_ROOT: begin
        rad_m_r  <= rad_m_r << 2;
        rad_h_r  <= rad_h_r << 2;
        rem_m_r  <= rem_m_nxt;
        rem_h_r  <= rem_h_nxt;
        root_m_r <= root_m_nxt;
        root_h_r <= root_h_nxt;
        x_r <= $signed(CW'({az_abs_r, 8'd0}));
        y_r <= $signed(CW'({root_h_nxt, 8'd0}));
        z_r <= '0;
      end
      S_ROT: begin
        if (y_r != '0) begin
          if (!y_r[CW-1]) begin
            x_r <= x_r + sy;
            y_r <= y_r - sx;
            z_r <= z_r + zt;
          end else begin
            x_r <= x_r - sy;
            y_r <= y_r + sx;
            z_r <= z_r - zt;
          end
        end
      end
      S_DONE: begin
        if (take) begin
          out_magnitude      <= (mag32 > 32'h0000_FFFF) ? 16'hFFFF : mag32[15:0];
          out_tilt_angle     <= tilt;
          out_impact         <= impact;
          out_fall_confirmed <= confirmed;
          out_status         <= status_nxt;
        end
      end
      default: ;
    endcase
  end

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tilt_angle <= aifd_pkg::TILT_MAX)
    else $error("tilt out of range");

  a_confirm_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fall_confirmed |-> out_status == aifd_pkg::ST_CONFIRMED)
    else $error("confirmed fall without confirmed status");

  a_impact_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == aifd_pkg::ST_IMPACT |-> out_impact)
    else $error("impact status without impact");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_SQR)
    else $error("accepted request did not start squaring");

endmodule
`default_nettype wire

@@ dv/accel_impact_fall_detector_tb.sv @@
// Self-checking testbench for the accelerometer impact and fall detector.
`timescale 1ns / 1ps
module accel_impact_fall_detector_tb;

  localparam logic [aifd_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [15:0] mag;
    logic [14:0] tilt;
    logic        impact;
    logic        fall;
    logic [1:0]  status;
  } reading_t;

  typedef struct {
    logic signed [15:0] ax, ay, az;
    logic [31:0]        t;
    bit                 typed;
    reading_t           want;
  } sample_row_t;

  localparam longint ATAN_STEP[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [aifd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [aifd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic [31:0] in_time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_magnitude;
  logic [14:0] out_tilt_angle;
  logic out_impact, out_fall_confirmed;
  logic [1:0] out_status;

  logic [15:0] thr_impact;
  logic [14:0] thr_tilt;
  logic [31:0] confirm_ms;
  bit          cand_open;
  logic [31:0] cand_since;
  logic [1:0]  status_now;

  reading_t pending_q[$];
  int errors = 0, requests = 0, readings = 0, falls = 0, impacts = 0;
  int idle_cycles = 0, stall_left = 0;
  bit calm = 1'b0;

  accel_impact_fall_detector i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_magnitude(out_magnitude), .out_tilt_angle(out_tilt_angle),
    .out_impact(out_impact), .out_fall_confirmed(out_fall_confirmed),
    .out_status(out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [14:0] tilt_from(longint unsigned h, longint unsigned vz);
    longint x, y, z, nx, ny, r;
    x = longint'(vz << 8);
    y = longint'(h << 8);
    z = 0;
    for (int i = 0; i < 16; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ATAN_STEP[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ATAN_STEP[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    r = (z + 128) >>> 8;
    if (r > 23040) r = 23040;
    return r[14:0];
  endfunction

  function automatic reading_t detect_fall(logic signed [15:0] ax, logic signed [15:0] ay,
                                           logic signed [15:0] az, logic [31:0] now);
    reading_t rd;
    longint unsigned sx, sy, sz, mag, h;
    sx = longint'(ax) * longint'(ax);
    sy = longint'(ay) * longint'(ay);
    sz = longint'(az) * longint'(az);
    mag = floor_sqrt(sx + sy + sz);
    h = floor_sqrt(sx + sy);
    rd.mag = (mag > 65535) ? 16'hFFFF : mag[15:0];
    rd.tilt = tilt_from(h, (az < 0) ? -longint'(az) : longint'(az));
    rd.impact = mag > thr_impact;
    rd.fall = 1'b0;
    if (rd.impact) status_now = aifd_pkg::ST_IMPACT;
    if (rd.tilt > thr_tilt) begin
      if (!cand_open) begin
        cand_open = 1'b1;
        cand_since = now;
      end
      if (now - cand_since >= confirm_ms) begin
        rd.fall = 1'b1;
        status_now = aifd_pkg::ST_CONFIRMED;
      end else if (!rd.impact) begin
        status_now = aifd_pkg::ST_CANDIDATE;
      end
    end else begin
      cand_open = 1'b0;
      cand_since = '0;
      if (!rd.impact) status_now = aifd_pkg::ST_NORMAL;
    end
    rd.status = status_now;
    return rd;
  endfunction

  task automatic flag_mismatch(string what, reading_t want, reading_t got);
    errors++;
    if (errors <= 10)
      $display("%s: want mag %0d tilt %0d imp %0b fall %0b st %0d, %s%0d %s%0d %s%0b %s%0b %s%0d",
               what, want.mag, want.tilt, want.impact, want.fall, want.status,
               "got mag ", got.mag, "tilt ", got.tilt, "imp ", got.impact,
               "fall ", got.fall, "st ", got.status);
  endtask

  // check results, watch for lack of progress and drive random output stalls
  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without progress", idle_cycles);
        $display("accel_impact_fall_detector_tb: errors");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{out_magnitude, out_tilt_angle, out_impact, out_fall_confirmed, out_status};
        readings++;
        if (pending_q.size() == 0) begin
          flag_mismatch("unexpected result", got, got);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) flag_mismatch("result mismatch", want, got);
        end
      end
      if (out_stall) begin
        if (stall_left <= 1) out_stall <= 1'b0;
        stall_left--;
      end else if (out_valid) begin
        stall_left = calm ? 0 : $urandom_range(0, 6);
        if (stall_left > 0) out_stall <= 1'b1;
      end
    end
  end

  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic [31:0] t,
                             bit typed, reading_t typed_want);
    int gap;
    reading_t rd;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_time_ms <= t;
    do @(posedge clk); while (in_stall);
    rd = detect_fall(ax, ay, az, t);
    if (typed && rd !== typed_want) flag_mismatch("directed row", typed_want, rd);
    pending_q.push_back(rd);
    requests++;
    falls += rd.fall;
    impacts += rd.impact;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [aifd_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      aifd_pkg::REG_IMPACT:  thr_impact = val[15:0];
      aifd_pkg::REG_TILT:    thr_tilt = val[14:0];
      aifd_pkg::REG_CONFIRM: confirm_ms = val;
      default: ;
    endcase
  endtask

  task automatic random_phase(int count);
    logic [31:0] t;
    logic signed [15:0] ax, ay, az;
    int kind;
    reading_t none;
    none = '0;
    t = $urandom;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      ax = 16'($urandom);
      ay = 16'($urandom);
      az = 16'($urandom);
      case (kind)
        0, 1, 2: begin
          az = 16'($urandom_range(2000, 6000));
          ax = $signed(16'($urandom_range(0, 1200))) - 16'sd600;
          ay = $signed(16'($urandom_range(0, 1200))) - 16'sd600;
        end
        3, 4, 5: begin
          az = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
          ax = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
        end
        6: ax = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
        default: ;
      endcase
      t = (kind == 9) ? $urandom : t + $urandom_range(0, 1500);
      send_sample(ax, ay, az, t, 1'b0, none);
    end
    calm = 1'b0;
  endtask

  sample_row_t directed[$];

  initial begin
    thr_impact = aifd_pkg::IMPACT_RST;
    thr_tilt = aifd_pkg::TILT_RST;
    confirm_ms = aifd_pkg::CONFIRM_RST;
    cand_open = 1'b0;
    cand_since = '0;
    status_now = aifd_pkg::ST_NORMAL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      '{16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b1,
        '{16'd0, 15'd0, 1'b0, 1'b0, aifd_pkg::ST_NORMAL}},
      '{16'sd0, 16'sd0, 16'sd4096, 32'd10, 1'b1,
        '{16'd4096, 15'd0, 1'b0, 1'b0, aifd_pkg::ST_NORMAL}},
      '{16'sd0, 16'sd0, -16'sd30000, 32'd20, 1'b1,
        '{16'd30000, 15'd0, 1'b1, 1'b0, aifd_pkg::ST_IMPACT}},
      '{16'sd4096, 16'sd0, 16'sd0, 32'd100, 1'b0, '0},
      '{16'sd0, -16'sd4096, 16'sd0, 32'd1000, 1'b0, '0},
      '{16'sd4096, 16'sd0, 16'sd0, 32'd2100, 1'b0, '0},
      '{16'sd20000, 16'sd0, 16'sd0, 32'd2200, 1'b0, '0},
      '{16'sd0, 16'sd0, 16'sd4096, 32'd2300, 1'b1,
        '{16'd4096, 15'd0, 1'b0, 1'b0, aifd_pkg::ST_NORMAL}},
      '{-16'sd4096, 16'sd0, 16'sd100, 32'd3000, 1'b0, '0},
      '{16'sd0, 16'sd20000, 16'sd0, 32'd3005, 1'b0, '0},
      '{16'sd0, 16'sd0, 16'sd4096, 32'd3010, 1'b0, '0},
      '{16'sd3000, 16'sd3000, 16'sd0, 32'd5000, 1'b0, '0},
      '{16'sd3000, 16'sd3000, 16'sd0, 32'd10, 1'b0, '0},
      '{16'sd0, 16'sd0, 16'sd4096, 32'hFFFF_FF00, 1'b0, '0},
      '{16'sd4000, 16'sd0, 16'sd1, 32'hFFFF_FFFF, 1'b0, '0},
      '{16'sd4000, 16'sd0, 16'sd1, 32'd1999, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 16'sd32767, 32'd2100, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 32'd2200, 1'b0, '0},
      '{-16'sd32768, 16'sd0, 16'sd0, 32'd2300, 1'b0, '0},
      '{16'sd0, 16'sd32767, 16'sd0, 32'd0, 1'b0, '0},
      '{16'sd0, 16'sd0, -16'sd32768, 32'd5, 1'b0, '0},
      '{16'sd1, 16'sd1, 16'sd1, 32'd6, 1'b0, '0},
      '{-16'sd1, 16'sd0, 16'sd0, 32'd7, 1'b0, '0}
    };
    foreach (directed[i])
      send_sample(directed[i].ax, directed[i].ay, directed[i].az, directed[i].t,
                  directed[i].typed, directed[i].want);

    random_phase(120);
    drain();
    write_reg(aifd_pkg::REG_IMPACT, 32'd0);
    write_reg(aifd_pkg::REG_TILT, 32'd0);
    write_reg(aifd_pkg::REG_CONFIRM, 32'd0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    random_phase(100);
    drain();
    write_reg(aifd_pkg::REG_IMPACT, 32'hFFFF_FFFF);
    write_reg(aifd_pkg::REG_TILT, 32'd23040);
    write_reg(aifd_pkg::REG_CONFIRM, 32'hFFFF_FFFF);
    random_phase(100);
    drain();
    write_reg(aifd_pkg::REG_TILT, 32'd22000);
    write_reg(aifd_pkg::REG_CONFIRM, 32'd1);
    random_phase(100);
    for (int p = 0; p < 3; p++) begin
      drain();
      write_reg(aifd_pkg::REG_IMPACT, $urandom_range(0, 65535));
      write_reg(aifd_pkg::REG_TILT, $urandom_range(0, 23040));
      write_reg(aifd_pkg::REG_CONFIRM, $urandom_range(0, 4000));
      random_phase(70);
    end
    drain();

    if (pending_q.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", pending_q.size());
    end
    $display("covered %0d requests and %0d results over seven threshold settings",
             requests, readings);
    $display("%0d impacts and %0d confirmed falls seen, %0d mismatches", impacts, falls,
             errors);
    if (errors == 0) $display("accel_impact_fall_detector_tb: clean");
    else $display("accel_impact_fall_detector_tb: errors");
    $finish;
  end
endmodule
